### design/pit_pkg.sv
`default_nettype none

package pit_pkg;

    localparam int COORD_WIDTH_DEF   = 20;
    localparam int FRACTION_BITS_DEF = 8;
    localparam int FIELD_COUNT       = 12;
    localparam int STAGES            = 11;

    localparam int PAD_WIDTH   = 19;
    localparam int LIMIT_WIDTH = 40;
    localparam int TOL_WIDTH   = 16;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 40;
    localparam int OUT_DATA_WIDTH  = 8;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HEIGHT_PADDING   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEGENERATE_LIMIT = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_EDGE_TOLERANCE   = 2'd2;

    localparam logic [PAD_WIDTH-1:0]   HEIGHT_PADDING_RST   = 19'd0;
    localparam logic [LIMIT_WIDTH-1:0] DEGENERATE_LIMIT_RST = 40'd4295;
    localparam logic [TOL_WIDTH-1:0]   EDGE_TOLERANCE_RST   = 16'd66;

    typedef enum logic [1:0] {
        OUT_INSIDE = 2'd0,
        OUT_HEIGHT = 2'd1,
        OUT_DEGEN  = 2'd2,
        OUT_PLANE  = 2'd3
    } pit_outcome_t;

    typedef struct packed {
        logic height_out;
        logic degen;
    } pit_flags_t;

endpackage

`default_nettype wire

### design/pit_front.sv
`default_nettype none

module pit_front #(
    parameter int COORD_WIDTH = pit_pkg::COORD_WIDTH_DEF
) (
    input  logic                                                clk,
    input  logic [2:0]                                          en,
    input  logic [pit_pkg::FIELD_COUNT*COORD_WIDTH-1:0]         coords,
    input  logic [pit_pkg::PAD_WIDTH-1:0]                       height_padding,
    output logic signed [2*(COORD_WIDTH+1):0]                   d00,
    output logic signed [2*(COORD_WIDTH+1):0]                   d01,
    output logic signed [2*(COORD_WIDTH+1):0]                   d02,
    output logic signed [2*(COORD_WIDTH+1):0]                   d11,
    output logic signed [2*(COORD_WIDTH+1):0]                   d12,
    output pit_pkg::pit_flags_t                                 flags
);
    import pit_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;
    localparam int MW = 2 * DW;
    localparam int PW = 2 * DW + 1;
    localparam int HW = ((W > PAD_WIDTH + 1) ? W : PAD_WIDTH + 1) + 2;

    logic signed [W-1:0] fld [FIELD_COUNT];

    for (genvar k = 0; k < FIELD_COUNT; k++) begin : g_fld
        assign fld[k] = $signed(coords[k*W +: W]);
    end

    logic signed [DW-1:0] e0x_next, e0z_next, e1x_next, e1z_next, e2x_next, e2z_next;
    logic signed [DW-1:0] e0x_reg, e0z_reg, e1x_reg, e1z_reg, e2x_reg, e2z_reg;
    logic signed [W-1:0]  lo1, hi1, lo_next, hi_next;
    logic signed [W-1:0]  py_reg, lo_reg, hi_reg;

    always_comb
    begin
        e0x_next = DW'(fld[9])  - DW'(fld[3]);
        e0z_next = DW'(fld[11]) - DW'(fld[5]);
        e1x_next = DW'(fld[6])  - DW'(fld[3]);
        e1z_next = DW'(fld[8])  - DW'(fld[5]);
        e2x_next = DW'(fld[0])  - DW'(fld[3]);
        e2z_next = DW'(fld[2])  - DW'(fld[5]);
        lo1      = (fld[7] < fld[4]) ? fld[7] : fld[4];
        lo_next  = (fld[10] < lo1) ? fld[10] : lo1;
        hi1      = (fld[7] > fld[4]) ? fld[7] : fld[4];
        hi_next  = (fld[10] > hi1) ? fld[10] : hi1;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            e0x_reg <= e0x_next;
            e0z_reg <= e0z_next;
            e1x_reg <= e1x_next;
            e1z_reg <= e1z_next;
            e2x_reg <= e2x_next;
            e2z_reg <= e2z_next;
            py_reg  <= fld[1];
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
        end
    end

    logic signed [MW-1:0] m00x_reg, m00z_reg, m01x_reg, m01z_reg, m02x_reg, m02z_reg;
    logic signed [MW-1:0] m11x_reg, m11z_reg, m12x_reg, m12z_reg;
    logic signed [HW-1:0] pad_w, band_lo, band_hi, py_w;
    logic                 height_next, height_reg;

    always_comb
    begin
        pad_w       = $signed(HW'(height_padding));
        py_w        = HW'(py_reg);
        band_lo     = HW'(lo_reg) - pad_w;
        band_hi     = HW'(hi_reg) + pad_w;
        height_next = (py_w < band_lo) || (py_w > band_hi);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            m00x_reg   <= MW'(e0x_reg) * MW'(e0x_reg);
            m00z_reg   <= MW'(e0z_reg) * MW'(e0z_reg);
            m01x_reg   <= MW'(e0x_reg) * MW'(e1x_reg);
            m01z_reg   <= MW'(e0z_reg) * MW'(e1z_reg);
            m02x_reg   <= MW'(e0x_reg) * MW'(e2x_reg);
            m02z_reg   <= MW'(e0z_reg) * MW'(e2z_reg);
            m11x_reg   <= MW'(e1x_reg) * MW'(e1x_reg);
            m11z_reg   <= MW'(e1z_reg) * MW'(e1z_reg);
            m12x_reg   <= MW'(e1x_reg) * MW'(e2x_reg);
            m12z_reg   <= MW'(e1z_reg) * MW'(e2z_reg);
            height_reg <= height_next;
        end
    end

    pit_flags_t flags_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            d00                  <= PW'(m00x_reg) + PW'(m00z_reg);
            d01                  <= PW'(m01x_reg) + PW'(m01z_reg);
            d02                  <= PW'(m02x_reg) + PW'(m02z_reg);
            d11                  <= PW'(m11x_reg) + PW'(m11z_reg);
            d12                  <= PW'(m12x_reg) + PW'(m12z_reg);
            flags_reg.height_out <= height_reg;
            flags_reg.degen      <= 1'b0;
        end
    end

    assign flags = flags_reg;

endmodule

`default_nettype wire

### design/pit_gram.sv
`default_nettype none

module pit_gram #(
    parameter int COORD_WIDTH = pit_pkg::COORD_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic [2:0]                          en,
    input  logic signed [2*(COORD_WIDTH+1):0]   d00,
    input  logic signed [2*(COORD_WIDTH+1):0]   d01,
    input  logic signed [2*(COORD_WIDTH+1):0]   d02,
    input  logic signed [2*(COORD_WIDTH+1):0]   d11,
    input  logic signed [2*(COORD_WIDTH+1):0]   d12,
    input  pit_pkg::pit_flags_t                 flags_in,
    output logic signed [4*(COORD_WIDTH+1)+2:0] den,
    output logic signed [4*(COORD_WIDTH+1)+2:0] un,
    output logic signed [4*(COORD_WIDTH+1)+2:0] vn,
    output pit_pkg::pit_flags_t                 flags_out
);
    import pit_pkg::*;

    localparam int DW    = COORD_WIDTH + 1;
    localparam int PW    = 2 * DW + 1;
    localparam int NW    = 2 * PW + 1;
    localparam int PRW   = 2 * PW;
    localparam int H     = (PW + 1) / 2;
    localparam int PPW   = 2 * (H + 1);
    localparam int NPROD = 6;

    // Each operand of a wide product is split into a low unsigned half and a high signed half.
    logic signed [PW-1:0]  opa [NPROD];
    logic signed [PW-1:0]  opb [NPROD];
    logic signed [H:0]     a_lo [NPROD];
    logic signed [H:0]     b_lo [NPROD];
    logic signed [PW-H-1:0] a_hi [NPROD];
    logic signed [PW-H-1:0] b_hi [NPROD];

    always_comb
    begin
        opa[0] = d00; opb[0] = d11;
        opa[1] = d01; opb[1] = d01;
        opa[2] = d11; opb[2] = d02;
        opa[3] = d01; opb[3] = d12;
        opa[4] = d00; opb[4] = d12;
        opa[5] = d01; opb[5] = d02;
        for (int j = 0; j < NPROD; j++)
        begin
            a_lo[j] = $signed({1'b0, opa[j][H-1:0]});
            b_lo[j] = $signed({1'b0, opb[j][H-1:0]});
            a_hi[j] = $signed(opa[j][PW-1:H]);
            b_hi[j] = $signed(opb[j][PW-1:H]);
        end
    end

    logic signed [PPW-1:0] ll_reg [NPROD];
    logic signed [PPW-1:0] lh_reg [NPROD];
    logic signed [PPW-1:0] hl_reg [NPROD];
    logic signed [PPW-1:0] hh_reg [NPROD];
    pit_flags_t            flags4_reg, flags5_reg, flags6_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int j = 0; j < NPROD; j++)
            begin
                ll_reg[j] <= PPW'(a_lo[j]) * PPW'(b_lo[j]);
                lh_reg[j] <= PPW'(a_lo[j]) * PPW'(b_hi[j]);
                hl_reg[j] <= PPW'(a_hi[j]) * PPW'(b_lo[j]);
                hh_reg[j] <= PPW'(a_hi[j]) * PPW'(b_hi[j]);
            end
            flags4_reg <= flags_in;
        end
    end

    logic signed [PRW-1:0] prod_next [NPROD];
    logic signed [PRW-1:0] prod_reg  [NPROD];

    always_comb
    begin
        for (int j = 0; j < NPROD; j++)
        begin
            prod_next[j] = (PRW'(hh_reg[j]) << (2 * H))
                         + ((PRW'(lh_reg[j]) + PRW'(hl_reg[j])) << H)
                         + PRW'(ll_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int j = 0; j < NPROD; j++)
            begin
                prod_reg[j] <= prod_next[j];
            end
            flags5_reg <= flags4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            den        <= NW'(prod_reg[0]) - NW'(prod_reg[1]);
            un         <= NW'(prod_reg[2]) - NW'(prod_reg[3]);
            vn         <= NW'(prod_reg[4]) - NW'(prod_reg[5]);
            flags6_reg <= flags5_reg;
        end
    end

    assign flags_out = flags6_reg;

endmodule

`default_nettype wire

### design/pit_bound.sv
`default_nettype none

module pit_bound #(
    parameter int COORD_WIDTH   = pit_pkg::COORD_WIDTH_DEF,
    parameter int FRACTION_BITS = pit_pkg::FRACTION_BITS_DEF
) (
    input  logic                                clk,
    input  logic [4:0]                          en,
    input  logic signed [4*(COORD_WIDTH+1)+2:0] den,
    input  logic signed [4*(COORD_WIDTH+1)+2:0] un,
    input  logic signed [4*(COORD_WIDTH+1)+2:0] vn,
    input  pit_pkg::pit_flags_t                 flags_in,
    input  logic [pit_pkg::LIMIT_WIDTH-1:0]     degenerate_limit,
    input  logic [pit_pkg::TOL_WIDTH-1:0]       edge_tolerance,
    output logic                                inside_res,
    output pit_pkg::pit_outcome_t               outcome
);
    import pit_pkg::*;

    localparam int NW   = 4 * (COORD_WIDTH + 1) + 3;
    localparam int FS   = 4 * FRACTION_BITS;
    localparam int DGW  = ((NW + 32 > LIMIT_WIDTH + FS) ? NW + 32 : LIMIT_WIDTH + FS) + 1;
    localparam int CHW  = 32;
    localparam int NCH  = (NW + CHW - 1) / CHW;
    localparam int TPW  = CHW + TOL_WIDTH;
    localparam int EW   = NW + TOL_WIDTH;
    localparam int CMPW = NW + TOL_WIDTH + 2;

    logic signed [NW-1:0] den_neg;
    logic [NW-1:0]        den_abs_next, den_abs_reg;
    logic [DGW-1:0]       deg_lhs, deg_rhs;
    logic signed [NW-1:0] un7_reg, vn7_reg;
    pit_flags_t           flags7_reg;

    always_comb
    begin
        den_neg      = -den;
        den_abs_next = den[NW-1] ? den_neg : den;
        deg_lhs      = DGW'(den_abs_next) << 32;
        deg_rhs      = DGW'(degenerate_limit) << FS;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            den_abs_reg      <= den_abs_next;
            un7_reg          <= un;
            vn7_reg          <= vn;
            flags7_reg.height_out <= flags_in.height_out;
            flags7_reg.degen      <= deg_lhs < deg_rhs;
        end
    end

    logic [NCH*CHW-1:0]   den_pad;
    logic [TPW-1:0]       tp_reg [NCH];
    logic [NW-1:0]        den_abs8_reg;
    logic signed [NW-1:0] un8_reg, vn8_reg;
    pit_flags_t           flags8_reg;

    assign den_pad = (NCH*CHW)'(den_abs_reg);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int k = 0; k < NCH; k++)
            begin
                tp_reg[k] <= TPW'(den_pad[k*CHW +: CHW]) * TPW'(edge_tolerance);
            end
            den_abs8_reg <= den_abs_reg;
            un8_reg      <= un7_reg;
            vn8_reg      <= vn7_reg;
            flags8_reg   <= flags7_reg;
        end
    end

    logic [EW-1:0]        eps_next, eps_reg;
    logic signed [NW:0]   uv_reg;
    logic [NW-1:0]        den_abs9_reg;
    logic signed [NW-1:0] un9_reg, vn9_reg;
    pit_flags_t           flags9_reg;

    always_comb
    begin
        eps_next = '0;
        for (int k = 0; k < NCH; k++)
        begin
            eps_next = eps_next + (EW'(tp_reg[k]) << (k * CHW));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            eps_reg      <= eps_next;
            uv_reg       <= (NW+1)'(un8_reg) + (NW+1)'(vn8_reg);
            den_abs9_reg <= den_abs8_reg;
            un9_reg      <= un8_reg;
            vn9_reg      <= vn8_reg;
            flags9_reg   <= flags8_reg;
        end
    end

    logic signed [CMPW-1:0] eps_w, den_w;
    logic signed [CMPW-1:0] neg_eps_reg, rhs_reg, un_s_reg, vn_s_reg, uv_s_reg;
    pit_flags_t             flags10_reg;

    always_comb
    begin
        eps_w = $signed(CMPW'(eps_reg));
        den_w = $signed(CMPW'(den_abs9_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            neg_eps_reg <= -eps_w;
            rhs_reg     <= (den_w << TOL_WIDTH) + eps_w;
            un_s_reg    <= CMPW'(un9_reg) << TOL_WIDTH;
            vn_s_reg    <= CMPW'(vn9_reg) << TOL_WIDTH;
            uv_s_reg    <= CMPW'(uv_reg) << TOL_WIDTH;
            flags10_reg <= flags9_reg;
        end
    end

    pit_outcome_t outcome_next, outcome_reg;
    logic         inside_reg;

    always_comb
    begin
        priority if (flags10_reg.height_out)
        begin
            outcome_next = OUT_HEIGHT;
        end
        else if (flags10_reg.degen)
        begin
            outcome_next = OUT_DEGEN;
        end
        else if ((un_s_reg < neg_eps_reg) || (vn_s_reg < neg_eps_reg)
                 || (rhs_reg < uv_s_reg))
        begin
            outcome_next = OUT_PLANE;
        end
        else
        begin
            outcome_next = OUT_INSIDE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            outcome_reg <= outcome_next;
            inside_reg  <= (outcome_next == OUT_INSIDE);
        end
    end

    assign outcome    = outcome_reg;
    assign inside_res = inside_reg;

endmodule

`default_nettype wire

### design/point_in_triangle_test_unit.sv
`default_nettype none

// Point-in-triangle test for navigation meshes. Each transfer on the input stream
// carries a query point and three triangle corners in signed fixed point; the unit
// returns one result per query telling whether the point is inside, above or below
// the height band, on a degenerate triangle, or outside the triangle in the
// horizontal plane. The unit is an eleven-stage pipeline that takes one query per
// clock cycle while the output is not stalled; every stage holds while the stage
// after it is full and stalled, so empty stages still fill behind a waiting
// result. The configuration registers
// should only be written while no query is in flight.
module point_in_triangle_test_unit #(
    parameter int COORD_WIDTH   = pit_pkg::COORD_WIDTH_DEF,
    parameter int FRACTION_BITS = pit_pkg::FRACTION_BITS_DEF
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                s_axis_tvalid,
    output logic                                                s_axis_tready,
    // Fields from bit 0 up: point_x, point_y, point_z, corner_a_x, corner_a_y,
    // corner_a_z, corner_b_x, corner_b_y, corner_b_z, corner_c_x, corner_c_y,
    // corner_c_z, then zero fill to whole bytes.
    input  logic [((pit_pkg::FIELD_COUNT*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                                                m_axis_tvalid,
    input  logic                                                m_axis_tready,
    // Fields from bit 0 up: inside_res, outcome, then zero fill.
    output logic [pit_pkg::OUT_DATA_WIDTH-1:0]                  m_axis_tdata,
    input  logic                                                cfg_valid,
    output logic                                                cfg_ready,
    input  logic [pit_pkg::CFG_INDEX_WIDTH-1:0]                 cfg_index,
    input  logic [pit_pkg::CFG_DATA_WIDTH-1:0]                  cfg_data
);
    import pit_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int PW = 2 * (W + 1) + 1;
    localparam int NW = 2 * PW + 1;

    logic [PAD_WIDTH-1:0]   height_padding_reg;
    logic [LIMIT_WIDTH-1:0] degenerate_limit_reg;
    logic [TOL_WIDTH-1:0]   edge_tolerance_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_padding_reg   <= HEIGHT_PADDING_RST;
            degenerate_limit_reg <= DEGENERATE_LIMIT_RST;
            edge_tolerance_reg   <= EDGE_TOLERANCE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_HEIGHT_PADDING:   height_padding_reg   <= cfg_data[PAD_WIDTH-1:0];
                REG_DEGENERATE_LIMIT: degenerate_limit_reg <= cfg_data[LIMIT_WIDTH-1:0];
                REG_EDGE_TOLERANCE:   edge_tolerance_reg   <= cfg_data[TOL_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    logic [STAGES-1:0] valid_reg, valid_next, en;

    always_comb
    begin
        en[STAGES-1] = ~valid_reg[STAGES-1] | m_axis_tready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            en[k] = ~valid_reg[k] | en[k+1];
        end
        valid_next[0] = en[0] ? s_axis_tvalid : valid_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = valid_reg[STAGES-1];

    logic signed [PW-1:0] d00, d01, d02, d11, d12;
    logic signed [NW-1:0] den, un, vn;
    pit_flags_t           front_flags, gram_flags;
    logic                 inside_res;
    pit_outcome_t         outcome;

    pit_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .clk           (clk),
        .en            (en[2:0]),
        .coords        (s_axis_tdata[FIELD_COUNT*W-1:0]),
        .height_padding(height_padding_reg),
        .d00           (d00),
        .d01           (d01),
        .d02           (d02),
        .d11           (d11),
        .d12           (d12),
        .flags         (front_flags)
    );

    pit_gram #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_gram (
        .clk      (clk),
        .en       (en[5:3]),
        .d00      (d00),
        .d01      (d01),
        .d02      (d02),
        .d11      (d11),
        .d12      (d12),
        .flags_in (front_flags),
        .den      (den),
        .un       (un),
        .vn       (vn),
        .flags_out(gram_flags)
    );

    pit_bound #(
        .COORD_WIDTH  (COORD_WIDTH),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_bound (
        .clk             (clk),
        .en              (en[10:6]),
        .den             (den),
        .un              (un),
        .vn              (vn),
        .flags_in        (gram_flags),
        .degenerate_limit(degenerate_limit_reg),
        .edge_tolerance  (edge_tolerance_reg),
        .inside_res      (inside_res),
        .outcome         (outcome)
    );

    assign m_axis_tdata = {{(OUT_DATA_WIDTH-3){1'b0}}, outcome, inside_res};

endmodule

`default_nettype wire

### tb/sv/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pit_pkg::*;

    localparam int COORD_W     = COORD_WIDTH_DEF;
    localparam int QUERY_W     = ((FIELD_COUNT * COORD_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 140;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

    typedef logic [QUERY_W-1:0] query_t;
    typedef logic signed [191:0] wide_t;

    localparam wide_t UNIT_Q16 = 192'sd65536;

    logic                       clk;
    logic                       rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [QUERY_W-1:0]         s_axis_tdata;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [OUT_DATA_WIDTH-1:0]  m_axis_tdata;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;

    logic [PAD_WIDTH-1:0]   pad_cfg   = HEIGHT_PADDING_RST;
    logic [LIMIT_WIDTH-1:0] limit_cfg = DEGENERATE_LIMIT_RST;
    logic [TOL_WIDTH-1:0]   tol_cfg   = EDGE_TOLERANCE_RST;

    query_t       pending_queries[$];
    pit_outcome_t expected_outcomes[$];
    pit_outcome_t due_outcome;
    logic         query_taken = 1'b0;
    int           queries_queued = 0;
    int           queries_accepted = 0;
    int           mismatch_count = 0;
    int           cycle_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;

    point_in_triangle_test_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    function automatic pit_outcome_t triangle_outcome(input query_t q);
        wide_t c[FIELD_COUNT];
        wide_t lo, hi, padw, limw, tolw;
        wide_t e0x, e0z, e1x, e1z, e2x, e2z;
        wide_t d00, d01, d02, d11, d12, den, un, vn, eps_den;
        for (int k = 0; k < FIELD_COUNT; k++)
        begin
            c[k] = wide_t'($signed(q[k*COORD_W +: COORD_W]));
        end
        lo = c[4];
        hi = c[4];
        if (c[7] < lo)
            lo = c[7];
        if (c[10] < lo)
            lo = c[10];
        if (c[7] > hi)
            hi = c[7];
        if (c[10] > hi)
            hi = c[10];
        padw = wide_t'(pad_cfg);
        if (c[1] < lo - padw || c[1] > hi + padw)
            return OUT_HEIGHT;

        e0x = c[9] - c[3];
        e0z = c[11] - c[5];
        e1x = c[6] - c[3];
        e1z = c[8] - c[5];
        e2x = c[0] - c[3];
        e2z = c[2] - c[5];
        d00 = e0x * e0x + e0z * e0z;
        d01 = e0x * e1x + e0z * e1z;
        d02 = e0x * e2x + e0z * e2z;
        d11 = e1x * e1x + e1z * e1z;
        d12 = e1x * e2x + e1z * e2z;

        den = d00 * d11 - d01 * d01;
        if (den[$bits(wide_t)-1])
            den = -den;
        limw = wide_t'(limit_cfg);
        if ((den <<< 32) < (limw <<< (4 * FRACTION_BITS_DEF)))
            return OUT_DEGEN;

        un = d11 * d02 - d01 * d12;
        vn = d00 * d12 - d01 * d02;
        tolw = wide_t'(tol_cfg);
        eps_den = den * tolw;
        if ((un <<< 16) < -eps_den || (vn <<< 16) < -eps_den)
            return OUT_PLANE;
        if (den * (UNIT_Q16 + tolw) < ((un + vn) <<< 16))
            return OUT_PLANE;
        return OUT_INSIDE;
    endfunction

    function automatic query_t q_of(input int px, py, pz, ax, ay, az,
                                    input int bx, by, bz, cx, cy, cz);
        query_t q;
        q = '0;
        q[FIELD_COUNT*COORD_W-1:0] = {cz[COORD_W-1:0], cy[COORD_W-1:0], cx[COORD_W-1:0],
                                      bz[COORD_W-1:0], by[COORD_W-1:0], bx[COORD_W-1:0],
                                      az[COORD_W-1:0], ay[COORD_W-1:0], ax[COORD_W-1:0],
                                      pz[COORD_W-1:0], py[COORD_W-1:0], px[COORD_W-1:0]};
        return q;
    endfunction

    function automatic int jitter(input int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    function automatic logic [CFG_DATA_WIDTH-1:0] random_word();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[CFG_DATA_WIDTH-1:0];
    endfunction

    // Most queries are built around a real triangle so that they get past the height
    // band and the degenerate check; the rest are raw noise or tiny or collapsed triangles.
    function automatic query_t make_query();
        int f[FIELD_COUNT];
        int origin[3];
        int pick, span, hspan, u, v, lo, hi, pad, m;
        pick = int'($urandom_range(99));
        if (pick >= 15 && pick < 25)
            span = int'($urandom_range(12, 1));
        else
            span = 1 << $urandom_range(18, 1);
        hspan = 1 << $urandom_range(16, 0);
        for (int k = 0; k < 3; k++)
        begin
            origin[k] = int'($urandom_range(524286)) - 262143;
        end
        for (int k = 3; k < FIELD_COUNT; k++)
        begin
            f[k] = origin[k % 3] + jitter((k % 3 == 1) ? hspan : span);
        end
        lo = f[4];
        hi = f[4];
        if (f[7] < lo)
            lo = f[7];
        if (f[10] < lo)
            lo = f[10];
        if (f[7] > hi)
            hi = f[7];
        if (f[10] > hi)
            hi = f[10];
        pad = int'(pad_cfg);

        if (pick < 15)
        begin
            for (int k = 0; k < FIELD_COUNT; k++)
            begin
                f[k] = int'($urandom);
            end
        end
        else if (pick < 25)
        begin
            m = int'($urandom_range(4)) - 2;
            if (pick < 20)
            begin
                f[9] = f[3] + m * (f[6] - f[3]);
                f[11] = f[5] + m * (f[8] - f[5]);
            end
            f[0] = f[3];
            f[1] = f[4];
            f[2] = f[5];
        end
        else
        begin
            if ($urandom_range(9) == 0)
            begin
                u = 256 * int'($urandom_range(1));
                v = (u == 0) ? 256 * int'($urandom_range(1)) : 0;
            end
            else
            begin
                u = int'($urandom_range(266)) - 5;
                v = int'($urandom_range(266 - u)) - 5;
            end
            f[0] = f[3] + ((f[6] - f[3]) * u + (f[9] - f[3]) * v) / 256;
            f[2] = f[5] + ((f[8] - f[5]) * u + (f[11] - f[5]) * v) / 256;
            case ($urandom_range(9))
                0: f[1] = lo - pad + jitter(1);
                1: f[1] = hi + pad + jitter(1);
                default: f[1] = lo + int'($urandom_range(hi - lo));
            endcase
        end
        return q_of(f[0], f[1], f[2], f[3], f[4], f[5],
                    f[6], f[7], f[8], f[9], f[10], f[11]);
    endfunction

    task automatic queue_query(input query_t q);
        pending_queries.push_back(q);
        queries_queued++;
    endtask

    // Bits above a register's width carry random junk; the block must drop them.
    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] value);
        logic [CFG_DATA_WIDTH-1:0] junk;
        junk = random_word();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        case (idx)
            REG_HEIGHT_PADDING:
                cfg_data <= {junk[CFG_DATA_WIDTH-1:PAD_WIDTH], value[PAD_WIDTH-1:0]};
            REG_EDGE_TOLERANCE:
                cfg_data <= {junk[CFG_DATA_WIDTH-1:TOL_WIDTH], value[TOL_WIDTH-1:0]};
            default:
                cfg_data <= value;
        endcase
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (cfg_index)
            REG_HEIGHT_PADDING:   pad_cfg = cfg_data[PAD_WIDTH-1:0];
            REG_DEGENERATE_LIMIT: limit_cfg = cfg_data[LIMIT_WIDTH-1:0];
            REG_EDGE_TOLERANCE:   tol_cfg = cfg_data[TOL_WIDTH-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (queries_accepted != queries_queued || expected_outcomes.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || query_taken)
            begin
                if (pending_queries.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_axis_tdata <= pending_queries.pop_front();
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            query_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_outcomes.push_back(triangle_outcome(s_axis_tdata));
                queries_accepted++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    $error("result transfer with no query outstanding: inside_res %0d, outcome %0d",
                           m_axis_tdata[0], m_axis_tdata[2:1]);
                    mismatch_count++;
                end
                else
                begin
                    due_outcome = expected_outcomes.pop_front();
                    if (m_axis_tdata[0] !== (due_outcome == OUT_INSIDE))
                    begin
                        $error("inside_res: expected %0d, actual %0d",
                               due_outcome == OUT_INSIDE, m_axis_tdata[0]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[2:1] !== due_outcome)
                    begin
                        $error("outcome: expected %0d, actual %0d",
                               due_outcome, m_axis_tdata[2:1]);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[point_in_triangle_test_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_HEIGHT_PADDING;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: no height padding, default degenerate limit and tolerance.
        queue_query(q_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_query(q_of(524287, 524287, 524287, 524287, 524287, 524287,
                         524287, 524287, 524287, 524287, 524287, 524287));
        queue_query(q_of(-524288, -524288, -524288, -524288, -524288, -524288,
                         -524288, -524288, -524288, -524288, -524288, -524288));
        queue_query(q_of(-524288, 0, -524288, -524288, 0, -524288,
                         524287, 0, -524288, -524288, 0, 524287));
        queue_query(q_of(0, 0, 0, -524288, 0, -524288,
                         524287, 0, -524288, -524288, 0, 524287));
        queue_query(q_of(524287, 0, 524287, -524288, 0, -524288,
                         524287, 0, -524288, -524288, 0, 524287));
        queue_query(q_of(0, 524287, 0, -524288, 0, -524288,
                         524287, 0, -524288, -524288, 0, 524287));
        queue_query(q_of(0, -524288, 0, -524288, 0, -524288,
                         524287, 0, -524288, -524288, 0, 524287));
        queue_query(q_of(64, -256, 64, 0, -256, 0, 256, 0, 0, 0, 512, 256));
        queue_query(q_of(64, 512, 64, 0, -256, 0, 256, 0, 0, 0, 512, 256));
        queue_query(q_of(64, -257, 64, 0, -256, 0, 256, 0, 0, 0, 512, 256));
        queue_query(q_of(64, 513, 64, 0, -256, 0, 256, 0, 0, 0, 512, 256));
        queue_query(q_of(128, 0, 128, 0, -256, 0, 256, 0, 0, 0, 512, 256));
        queue_query(q_of(129, 0, 129, 0, -256, 0, 256, 0, 0, 0, 512, 256));
        queue_query(q_of(-1, 0, 64, 0, -256, 0, 256, 0, 0, 0, 512, 256));
        queue_query(q_of(64, 0, -1, 0, -256, 0, 256, 0, 0, 0, 512, 256));
        queue_query(q_of(256, 0, 0, 0, -256, 0, 256, 0, 0, 0, 512, 256));
        queue_query(q_of(0, 0, 256, 0, -256, 0, 256, 0, 0, 0, 512, 256));
        queue_query(q_of(64, 0, 64, 0, 0, 0, 0, 0, 256, 256, 0, 0));
        queue_query(q_of(0, 0, 0, 0, 0, 0, 8, 0, 0, 0, 0, 8));
        queue_query(q_of(0, 0, 0, 0, 0, 0, 9, 0, 0, 0, 0, 9));
        queue_query(q_of(128, 0, 128, 0, 0, 0, 256, 0, 256, 512, 0, 512));
        queue_query(q_of(10, 0, 10, 0, 0, 0, 0, 0, 0, 256, 0, 256));
        queue_query(q_of(349525, 349525, 349525, -349526, -349526, -349526,
                         -349526, -349526, -349526, -349526, -349526, -349526));
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(REG_UNUSED, random_word());
                    write_reg(REG_HEIGHT_PADDING, 40'd64);
                    write_reg(REG_DEGENERATE_LIMIT, DEGENERATE_LIMIT_RST);
                    write_reg(REG_EDGE_TOLERANCE, 40'(EDGE_TOLERANCE_RST));
                end
                1:
                begin
                    write_reg(REG_HEIGHT_PADDING, 40'h7FFFF);
                    write_reg(REG_DEGENERATE_LIMIT, 40'd0);
                    write_reg(REG_EDGE_TOLERANCE, 40'd0);
                end
                2:
                begin
                    write_reg(REG_HEIGHT_PADDING, 40'd0);
                    write_reg(REG_DEGENERATE_LIMIT, 40'hFF_FFFF_FFFF);
                    write_reg(REG_EDGE_TOLERANCE, 40'hFFFF);
                end
                3:
                begin
                    write_reg(REG_HEIGHT_PADDING, 40'd256);
                    write_reg(REG_DEGENERATE_LIMIT, 40'h01_0000_0000);
                    write_reg(REG_EDGE_TOLERANCE, 40'd1);
                end
                default:
                begin
                    write_reg(REG_HEIGHT_PADDING, 40'($urandom_range(4096)));
                    if ($urandom_range(1) == 0)
                        write_reg(REG_DEGENERATE_LIMIT, 40'($urandom_range(1 << 20)));
                    else
                        write_reg(REG_DEGENERATE_LIMIT, random_word());
                    write_reg(REG_EDGE_TOLERANCE, random_word());
                    write_reg(REG_UNUSED, random_word());
                end
            endcase
            case (phase % 4)
                0:
                begin
                    send_idle_pct <= 0;
                    recv_stall_pct <= 0;
                end
                1:
                begin
                    send_idle_pct <= 77;
                    recv_stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct <= 0;
                    recv_stall_pct <= 77;
                end
                default:
                begin
                    send_idle_pct <= 33;
                    recv_stall_pct <= 33;
                end
            endcase
            repeat (PHASE_ITEMS) queue_query(make_query());
            wait_drained();
        end

        repeat (2 * STAGES) @(negedge clk);
        if (mismatch_count == 0)
            $display("[point_in_triangle_test_unit] OK");
        else
            $display("[point_in_triangle_test_unit] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
design/pit_pkg.sv
design/pit_front.sv
design/pit_gram.sv
design/pit_bound.sv
design/point_in_triangle_test_unit.sv
tb/sv/tb.sv
